/* src/assert_macros.svh */
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// condition holds in the same cycle as the trigger
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// condition holds in the cycle after the trigger
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_SAME(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

/* src/bbt_pkg.sv */
package bbt_pkg;

    localparam int MAX_WIDTH_DEF = 1024;
    localparam int MAX_HEIGHT    = 4096;

    // widths fixed by the register and field formats
    localparam int XW      = 11;
    localparam int HW      = 13;
    localparam int YW      = 14;
    localparam int CFG_IW  = 2;
    localparam int CFG_DW  = 13;
    localparam int CH_W    = 8;
    localparam int PIX_W   = 3 * CH_W;
    localparam int SUM_W   = 12;
    localparam int NUM_W   = 13;
    localparam int CNT_W   = 4;
    localparam int RCP_W   = 18;
    localparam int RCP_SH  = 18;
    localparam int PROD_W  = RCP_SH + CH_W;
    localparam int LANES   = 3;

    localparam logic [CFG_IW-1:0] REG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_IW-1:0] REG_IMAGE_HEIGHT = 2'd1;

    localparam logic [XW-1:0] WIDTH_RESET  = 11'd1024;
    localparam logic [HW-1:0] HEIGHT_RESET = 13'd1024;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_SUM,
        ST_MUL,
        ST_OUT
    } bbt_state_t;

    // which parts of the 3x3 window take part in one average
    typedef struct packed {
        logic             emit;
        logic             top;
        logic             bot;
        logic             left;
        logic             right;
        logic [CNT_W-1:0] count;
        logic             frame_end;
    } bbt_ctrl_t;

    function automatic logic [CNT_W-1:0] count_of(input logic top, input logic bot,
                                                  input logic left, input logic right);
        logic [1:0] rows;
        logic [1:0] cols;
        rows = 2'd1 + {1'b0, top} + {1'b0, bot};
        cols = 2'd1 + {1'b0, left} + {1'b0, right};
        return CNT_W'(rows * cols);
    endfunction

    // ceil(2^18 / (2*count)), exact floor division for 13-bit numerators
    function automatic logic [RCP_W-1:0] recip_of(input logic [CNT_W-1:0] count);
        logic [RCP_W-1:0] m;
        case (count)
            4'd1:    m = 18'd131072;
            4'd2:    m = 18'd65536;
            4'd3:    m = 18'd43691;
            4'd4:    m = 18'd32768;
            4'd6:    m = 18'd21846;
            4'd9:    m = 18'd14564;
            default: m = 18'd131072;
        endcase
        return m;
    endfunction

endpackage

/* src/bbt_ram.sv */
module bbt_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 1024
) (
    input  logic                                       aclk,
    input  logic                                       we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                           wdata,
    input  logic                                       re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                           rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* src/bbt_lane.sv */
module bbt_lane (
    input  logic                         aclk,
    input  logic [8:0][bbt_pkg::CH_W-1:0] pix,
    input  bbt_pkg::bbt_ctrl_t           ctrl,
    output logic [bbt_pkg::CH_W-1:0]     avg
);

    import bbt_pkg::*;

    logic [SUM_W-1:0]  sum_next;
    logic [SUM_W-1:0]  sum_reg;
    logic [NUM_W-1:0]  num;
    logic [PROD_W-1:0] prod_reg;
    logic [2:0]        row_en;
    logic [2:0]        col_en;

    // window index is row*3+col, row 0 on top
    always_comb begin
        row_en   = {ctrl.bot, 1'b1, ctrl.top};
        col_en   = {ctrl.right, 1'b1, ctrl.left};
        sum_next = '0;
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                if (row_en[i] && col_en[j]) begin
                    sum_next = sum_next + SUM_W'(pix[i*3+j]);
                end
            end
        end
    end

    // round half up: floor((2*sum + n) / (2*n))
    assign num = {sum_reg, 1'b0} + NUM_W'(ctrl.count);

    always_ff @(posedge aclk) begin
        sum_reg  <= sum_next;
        prod_reg <= PROD_W'(num * recip_of(ctrl.count));
    end

    assign avg = prod_reg[RCP_SH +: CH_W];

endmodule

/* src/bbt_merge.sv */
module bbt_merge (
    input  logic                                     aclk,
    input  logic                                     aresetn,
    input  logic                                     load,
    input  logic [bbt_pkg::LANES-1:0][bbt_pkg::CH_W-1:0] lane_avg,
    input  logic                                     frame_end,
    output logic                                     free,
    output logic                                     m_tvalid,
    input  logic                                     m_tready,
    output logic [bbt_pkg::PIX_W-1:0]                m_tdata,
    output logic                                     m_tlast
);

    import bbt_pkg::*;

    logic             valid_reg;
    logic [PIX_W-1:0] data_reg;
    logic             last_reg;

    assign free = !valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (load) begin
            valid_reg <= 1'b1;
        end else if (m_tready) begin
            valid_reg <= 1'b0;
        end
    end

    // red in the low byte, then green, then blue
    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= {lane_avg[2], lane_avg[1], lane_avg[0]};
            last_reg <= frame_end;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;
    assign m_tlast  = last_reg;

endmodule

/* src/box_blur_three_by_three.sv */
// 3x3 box blur for an rgb raster stream. pixels come in raster order on the s_ side, one per
// beat, with s_tuser low; after the last pixel of a frame the source sends image_width+1 drain
// beats (s_tuser high). the blurred pixel (r,c) leaves on the m_ side while the beat at stream
// position (r+1)*width+c+1 is processed, and m_tlast marks the frame's last blurred pixel.
// each channel is the average over the neighbours that lie inside the frame (divisor 9, 6, 4
// or less at the edges), rounded half up. red, green and blue run in three parallel lanes that
// each hold a summing stage and a reciprocal multiply stage; a merge stage packs the three
// lanes into the output register. a beat that yields no pixel passes through the take and the
// window update only; a beat that yields one passes through, in order, the take of the beat
// and the line store read, the window update, the sum, the multiply and the load into the
// output register, which waits out any back-pressure on m_tready. the next beat is taken while
// the previous result waits in the output register. writing either config register restarts
// the frame; write config only while the block is idle. no clearing pass is needed after reset.
`include "assert_macros.svh"

module box_blur_three_by_three #(
    parameter int MAX_WIDTH = bbt_pkg::MAX_WIDTH_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    // config write channel
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [bbt_pkg::CFG_IW-1:0]  cfg_index,
    input  logic [bbt_pkg::CFG_DW-1:0]  cfg_data,
    // pixel input
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [bbt_pkg::PIX_W-1:0]   s_tdata,   // red_in, green_in, blue_in
    input  logic                        s_tuser,   // func
    // blurred output
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [bbt_pkg::PIX_W-1:0]   m_tdata,   // red_out, green_out, blue_out
    output logic                        m_tlast    // frame_end
);

    import bbt_pkg::*;

    localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam logic [XW-1:0] MAX_W_CLIP =
        (MAX_WIDTH > (1 << XW) - 1) ? XW'((1 << XW) - 1) : XW'(MAX_WIDTH);
    localparam logic [HW-1:0] MAX_H_CLIP =
        (MAX_HEIGHT > (1 << HW) - 1) ? HW'((1 << HW) - 1) : HW'(MAX_HEIGHT);

    bbt_state_t state_reg, state_next;

    logic [XW-1:0]    width_reg;
    logic [HW-1:0]    height_reg;
    logic [XW-1:0]    col_reg, col_next;
    logic [YW-1:0]    row_reg, row_next;
    logic [XW-1:0]    w_eff;
    logic [HW-1:0]    h_eff;
    logic [YW-1:0]    h_ext;

    logic             accept;
    logic             cfg_wr;
    logic             out_free;
    logic             out_load;

    bbt_ctrl_t        ctrl_reg, ctrl_next;
    logic [PIX_W-1:0] px_reg, px_next;
    logic [AW-1:0]    addr_reg;

    // line store entry: upper line in the high half, middle line in the low half
    logic [2*PIX_W-1:0] ls_rdata;
    logic               ls_we;

    logic [2:0][2:0][PIX_W-1:0] win_reg;   // [row][col], row 0 on top, col 2 newest

    logic [LANES-1:0][8:0][CH_W-1:0] lane_pix;
    logic [LANES-1:0][CH_W-1:0]      lane_avg;

    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid && cfg_ready;
    assign s_tready  = (state_reg == ST_IDLE);
    assign accept    = s_tvalid && s_tready;

    // effective frame size: zero reads as one, too large saturates
    always_comb begin
        if (width_reg == '0) begin
            w_eff = XW'(1);
        end else if (32'(width_reg) > MAX_WIDTH) begin
            w_eff = MAX_W_CLIP;
        end else begin
            w_eff = width_reg;
        end
        if (height_reg == '0) begin
            h_eff = HW'(1);
        end else if (32'(height_reg) > MAX_HEIGHT) begin
            h_eff = MAX_H_CLIP;
        end else begin
            h_eff = height_reg;
        end
        h_ext = YW'(h_eff);
    end

    // what the beat at the current position yields
    always_comb begin
        logic          emit0;
        logic          emit1;
        logic [XW:0]   col_inc;
        logic [YW-1:0] row_inc;

        // column 0 closes the previous line's last pixel, other columns the pixel to the left
        emit0 = (col_reg == '0) && (row_reg >= YW'(2)) && (row_reg < h_ext + YW'(2));
        emit1 = (col_reg != '0) && (row_reg != '0) && (row_reg < h_ext + YW'(1));

        ctrl_next = '0;
        if (emit0) begin
            ctrl_next.emit      = 1'b1;
            ctrl_next.top       = (row_reg >= YW'(3));
            ctrl_next.bot       = (row_reg < h_ext + YW'(1));
            ctrl_next.left      = (w_eff > XW'(1));
            ctrl_next.right     = 1'b0;
            ctrl_next.frame_end = (row_reg == h_ext + YW'(1));
        end else if (emit1) begin
            ctrl_next.emit      = 1'b1;
            ctrl_next.top       = (row_reg >= YW'(2));
            ctrl_next.bot       = (row_reg < h_ext);
            ctrl_next.left      = (col_reg >= XW'(2));
            ctrl_next.right     = 1'b1;
            ctrl_next.frame_end = 1'b0;
        end
        ctrl_next.count = count_of(ctrl_next.top, ctrl_next.bot,
                                   ctrl_next.left, ctrl_next.right);

        // drain beats and beats past the last line carry a zero pixel
        if (!s_tuser && (row_reg < h_ext)) begin
            px_next = {s_tdata[7:0], s_tdata[15:8], s_tdata[23:16]};
        end else begin
            px_next = '0;
        end

        // stream position
        col_inc = {1'b0, col_reg} + (XW+1)'(1);
        row_inc = row_reg;
        col_next = col_reg;
        row_next = row_reg;
        if (cfg_wr && (cfg_index == REG_IMAGE_WIDTH || cfg_index == REG_IMAGE_HEIGHT)) begin
            col_next = '0;
            row_next = '0;
        end else if (accept) begin
            if (ctrl_next.frame_end) begin
                col_next = '0;
                row_next = '0;
            end else begin
                if (col_inc >= {1'b0, w_eff}) begin
                    col_next = '0;
                    row_inc  = row_reg + YW'(1);
                end else begin
                    col_next = col_inc[XW-1:0];
                end
                if (row_inc > h_ext + YW'(1)) begin
                    col_next = '0;
                    row_next = '0;
                end else begin
                    row_next = row_inc;
                end
            end
        end
    end

    // sequencer
    always_comb begin
        state_next = state_reg;
        out_load   = 1'b0;
        ls_we      = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = ST_READ;
                end
            end
            ST_READ: begin
                ls_we      = 1'b1;
                state_next = ctrl_reg.emit ? ST_SUM : ST_IDLE;
            end
            ST_SUM: begin
                state_next = ST_MUL;
            end
            ST_MUL: begin
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (out_free) begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            col_reg    <= '0;
            row_reg    <= '0;
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
        end else begin
            state_reg <= state_next;
            col_reg   <= col_next;
            row_reg   <= row_next;
            if (cfg_wr && cfg_index == REG_IMAGE_WIDTH) begin
                width_reg <= cfg_data[XW-1:0];
            end
            if (cfg_wr && cfg_index == REG_IMAGE_HEIGHT) begin
                height_reg <= cfg_data[HW-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            ctrl_reg <= ctrl_next;
            px_reg   <= px_next;
            addr_reg <= AW'(col_reg);
        end
    end

    // window slides one column on the line store read-back
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            win_reg <= '0;
        end else if (state_reg == ST_READ) begin
            for (int i = 0; i < 3; i++) begin
                win_reg[i][0] <= win_reg[i][1];
                win_reg[i][1] <= win_reg[i][2];
            end
            win_reg[0][2] <= ls_rdata[2*PIX_W-1:PIX_W];
            win_reg[1][2] <= ls_rdata[PIX_W-1:0];
            win_reg[2][2] <= px_reg;
        end
    end

    // two line stores share one address, so they sit side by side in one ram
    bbt_ram #(
        .WIDTH (2 * PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_store (
        .aclk  (aclk),
        .we    (ls_we),
        .waddr (addr_reg),
        .wdata ({ls_rdata[PIX_W-1:0], px_reg}),
        .re    (accept),
        .raddr (AW'(col_reg)),
        .rdata (ls_rdata)
    );

    // lane 0 red, lane 1 green, lane 2 blue; red sits in the top byte of a stored pixel
    always_comb begin
        for (int k = 0; k < LANES; k++) begin
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    lane_pix[k][i*3+j] = win_reg[i][j][(LANES-1-k)*CH_W +: CH_W];
                end
            end
        end
    end

    for (genvar k = 0; k < LANES; k++) begin : g_lane
        bbt_lane u_lane (
            .aclk (aclk),
            .pix  (lane_pix[k]),
            .ctrl (ctrl_reg),
            .avg  (lane_avg[k])
        );
    end

    bbt_merge u_merge (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load      (out_load),
        .lane_avg  (lane_avg),
        .frame_end (ctrl_reg.frame_end),
        .free      (out_free),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    // a taken beat always goes to the line store read
    `ASSERT_NEXT(a_accept_reads, aclk, aresetn, accept, state_reg == ST_READ)
    // never overwrite a result that is still waiting
    `ASSERT_SAME(a_no_overwrite, aclk, aresetn, out_load, !m_tvalid || m_tready)
    // the column counter stays inside the line
    `ASSERT_SAME(a_col_in_line, aclk, aresetn, 1'b1, col_reg < w_eff)
    // the frame's last pixel restarts the stream position
    `ASSERT_NEXT(a_frame_restart, aclk, aresetn, accept && ctrl_next.frame_end,
                 col_reg == '0 && row_reg == '0)

endmodule
